// ----- sv/v3an_pkg.sv -----
// Shared constants, types and helpers for the vec3 ALU.
`default_nettype none
package v3an_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int W          = 32;
  localparam int RAD_W      = 2 * W;
  localparam int SQ_STAGES  = W;
  localparam int DIV_W      = W + FRAC_BITS;
  localparam int DIV_STAGES = DIV_W;
  localparam int EXT_W      = 2 * W + 2;
  localparam int THR_W      = 16;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

  typedef enum logic [2:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_SCALE,
    MODE_DIV,
    MODE_DOT,
    MODE_CROSS,
    MODE_NORM,
    MODE_NORMALIZE
  } mode_t;

  typedef struct packed {
    logic [W-1:0] v;
    logic         ov;
  } sat_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0][W-1:0] a;
    logic [W-1:0]      s;
    logic [2:0][W-1:0] r;
    logic [W-1:0]      rs;
    logic              ov;
    logic              dz;
    logic              pass;
  } side_t;

  function automatic sat_t sat_ext(input logic signed [EXT_W-1:0] v);
    sat_t res;
    res.ov = !((&v[EXT_W-1:W-1]) || !(|v[EXT_W-1:W-1]));
    if (res.ov) begin
      res.v = v[EXT_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res.v = v[W-1:0];
    end
    return res;
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/v3an_if.sv -----
// Valid/ready channel interfaces for the vec3 ALU operand and result streams.
`default_nettype none
interface v3an_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic signed [31:0]  a_x;
  logic signed [31:0]  a_y;
  logic signed [31:0]  a_z;
  logic signed [31:0]  b_x;
  logic signed [31:0]  b_y;
  logic signed [31:0]  b_z;
  logic signed [31:0]  scalar_in;
  modport source(output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
  modport sink(input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

interface v3an_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  res_x;
  logic signed [31:0]  res_y;
  logic signed [31:0]  res_z;
  logic signed [31:0]  res_scalar;
  logic                overflow;
  logic                div_zero;
  modport source(output valid, res_x, res_y, res_z, res_scalar, overflow, div_zero,
                 input ready);
  modport sink(input valid, res_x, res_y, res_z, res_scalar, overflow, div_zero,
               output ready);
endinterface
`default_nettype wire

// ----- sv/v3an_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
`default_nettype none
module v3an_sqrt (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [v3an_pkg::RAD_W-1:0] rad,
  output logic      [v3an_pkg::W-1:0]    root
);

  localparam int W  = v3an_pkg::W;
  localparam int RW = v3an_pkg::RAD_W;
  localparam int N  = v3an_pkg::SQ_STAGES;

  logic [RW-1:0] rad_r [N];
  logic [W+2:0]  rem_r [N];
  logic [W-1:0]  root_r [N];
  logic [RW-1:0] rad_nxt [N];
  logic [W+2:0]  rem_nxt [N];
  logic [W-1:0]  root_nxt [N];

  always_comb begin
    logic [RW-1:0] rs;
    logic [W+2:0]  rm;
    logic [W+2:0]  r2;
    logic [W+2:0]  tr;
    logic [W-1:0]  rt;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rs = rad;
        rm = '0;
        rt = '0;
      end else begin
        rs = rad_r[k-1];
        rm = rem_r[k-1];
        rt = root_r[k-1];
      end
      r2 = {rm[W:0], rs[RW-1:RW-2]};
      tr = {1'b0, rt, 2'b01};
      if (r2 >= tr) begin
        rem_nxt[k]  = r2 - tr;
        root_nxt[k] = {rt[W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = r2;
        root_nxt[k] = {rt[W-2:0], 1'b0};
      end
      rad_nxt[k] = {rs[RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[N-1];

endmodule
`default_nettype wire

// ----- sv/v3an_div_lane.sv -----
// Pipelined restoring divider for one vector lane, one quotient bit per stage.
`default_nettype none
module v3an_div_lane (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [v3an_pkg::DIV_W-1:0] dividend,
  input  wire logic [v3an_pkg::W-1:0]    divisor,
  input  wire logic                      neg,
  output logic      [v3an_pkg::DIV_W-1:0] quot,
  output logic                           quot_neg
);

  localparam int W  = v3an_pkg::W;
  localparam int DW = v3an_pkg::DIV_W;
  localparam int N  = v3an_pkg::DIV_STAGES;

  logic [DW-1:0] nq_r [N];
  logic [W-1:0]  rem_r [N];
  logic [W-1:0]  d_r [N];
  logic          neg_r [N];
  logic [DW-1:0] nq_nxt [N];
  logic [W-1:0]  rem_nxt [N];
  logic [W-1:0]  d_nxt [N];
  logic          neg_nxt [N];

  always_comb begin
    logic [DW-1:0] nq;
    logic [W-1:0]  rm;
    logic [W:0]    r2;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        nq         = dividend;
        rm         = '0;
        d_nxt[k]   = divisor;
        neg_nxt[k] = neg;
      end else begin
        nq         = nq_r[k-1];
        rm         = rem_r[k-1];
        d_nxt[k]   = d_r[k-1];
        neg_nxt[k] = neg_r[k-1];
      end
      r2 = {rm, nq[DW-1]};
      if (r2 >= {1'b0, d_nxt[k]}) begin
        rem_nxt[k] = W'(r2 - {1'b0, d_nxt[k]});
        nq_nxt[k]  = {nq[DW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = r2[W-1:0];
        nq_nxt[k]  = {nq[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        nq_r[k]  <= nq_nxt[k];
        rem_r[k] <= rem_nxt[k];
        d_r[k]   <= d_nxt[k];
        neg_r[k] <= neg_nxt[k];
      end
    end
  end

  assign quot     = nq_r[N-1];
  assign quot_neg = neg_r[N-1];

endmodule
`default_nettype wire

// ----- sv/vec3_alu_normalize.sv -----
// Top level of the pipelined Q16.16 vec3 ALU with dot, cross, norm and normalize.
//
// Operands arrive on in_ch (valid/ready); each transfer carries a mode, vectors a
// and b and a scalar, and yields exactly one result transfer on out_ch.
// cfg_we/cfg_wdata write the 16-bit normalize threshold (reset value 7); write it
// only while no item is in flight.
// The datapath is one fixed pipeline: operand register, three-lane multiply
// stage, sum and saturate stage, a 32-stage square root, a 48-stage divider per
// lane and the output register. One item is taken every cycle when the output
// is drained.
// The square-root and divider stage counts set the latency.
// When out_ch.ready is low with a result held, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and restores the threshold.
`default_nettype none
module vec3_alu_normalize (
  input  wire logic   clk,
  input  wire logic   rst_n,
  v3an_in_if.sink     in_ch,
  v3an_out_if.source  out_ch,
  input  wire logic   cfg_we,
  input  wire logic [v3an_pkg::THR_W-1:0] cfg_wdata
);

  localparam int W    = v3an_pkg::W;
  localparam int FB   = v3an_pkg::FRAC_BITS;
  localparam int EW   = v3an_pkg::EXT_W;
  localparam int DW   = v3an_pkg::DIV_W;
  localparam int SQN  = v3an_pkg::SQ_STAGES;
  localparam int DVN  = v3an_pkg::DIV_STAGES;
  localparam int NV   = 3 + SQN + DVN;

  logic en;
  logic out_vld_r;
  logic [NV-1:0] vld_r;
  logic [v3an_pkg::THR_W-1:0] thr_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
      thr_r     <= v3an_pkg::THR_RESET;
    end else begin
      if (en) begin
        vld_r     <= {vld_r[NV-2:0], in_ch.valid};
        out_vld_r <= vld_r[NV-1];
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // operand register
  v3an_pkg::mode_t    mode0_r;
  logic signed [W-1:0] a0_r [3];
  logic signed [W-1:0] b0_r [3];
  logic signed [W-1:0] s0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r <= v3an_pkg::mode_t'(in_ch.mode);
      a0_r[0] <= in_ch.a_x;
      a0_r[1] <= in_ch.a_y;
      a0_r[2] <= in_ch.a_z;
      b0_r[0] <= in_ch.b_x;
      b0_r[1] <= in_ch.b_y;
      b0_r[2] <= in_ch.b_z;
      s0_r    <= in_ch.scalar_in;
    end
  end

  // multiply stage, one lane per component
  v3an_pkg::mode_t      mode1_r;
  logic signed [W-1:0]   a1_r [3];
  logic signed [W-1:0]   s1_r;
  logic signed [W:0]     sum1_r [3];
  logic signed [W:0]     dif1_r [3];
  logic signed [2*W-1:0] ps1_r [3];
  logic signed [2*W-1:0] pd1_r [3];
  logic signed [2*W-1:0] pcp1_r [3];
  logic signed [2*W-1:0] pcn1_r [3];
  logic [2*W-1:0]        sq1_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        a1_r[i]   <= a0_r[i];
        sum1_r[i] <= (W+1)'(a0_r[i]) + (W+1)'(b0_r[i]);
        dif1_r[i] <= (W+1)'(a0_r[i]) - (W+1)'(b0_r[i]);
        ps1_r[i]  <= a0_r[i] * s0_r;
        pd1_r[i]  <= a0_r[i] * b0_r[i];
        pcp1_r[i] <= a0_r[J] * b0_r[K];
        pcn1_r[i] <= a0_r[K] * b0_r[J];
        sq1_r[i]  <= v3an_pkg::mag(a0_r[i]) * v3an_pkg::mag(a0_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= mode0_r;
      s1_r    <= s0_r;
    end
  end

  // sum and saturate stage
  v3an_pkg::sat_t lane2 [3];
  v3an_pkg::sat_t dot2;
  v3an_pkg::side_t side2_nxt;
  v3an_pkg::side_t side2_r;
  logic [2*W-1:0] sqs2_r;

  for (genvar i = 0; i < 3; i++) begin : g_sum
    always_comb begin
      case (mode1_r)
        v3an_pkg::MODE_ADD:   lane2[i] = v3an_pkg::sat_ext(EW'(sum1_r[i]));
        v3an_pkg::MODE_SUB:   lane2[i] = v3an_pkg::sat_ext(EW'(dif1_r[i]));
        v3an_pkg::MODE_SCALE: lane2[i] = v3an_pkg::sat_ext(EW'(ps1_r[i]) >>> FB);
        v3an_pkg::MODE_CROSS:
          lane2[i] = v3an_pkg::sat_ext((EW'(pcp1_r[i]) - EW'(pcn1_r[i])) >>> FB);
        default:              lane2[i] = '0;
      endcase
    end
  end

  always_comb begin
    dot2 = v3an_pkg::sat_ext((EW'(pd1_r[0]) + EW'(pd1_r[1]) + EW'(pd1_r[2])) >>> FB);
    side2_nxt      = '0;
    side2_nxt.mode = mode1_r;
    side2_nxt.s    = s1_r;
    for (int i = 0; i < 3; i++) begin
      side2_nxt.a[i] = a1_r[i];
      side2_nxt.r[i] = lane2[i].v;
    end
    side2_nxt.ov = lane2[0].ov | lane2[1].ov | lane2[2].ov;
    if (mode1_r == v3an_pkg::MODE_DOT) begin
      side2_nxt.rs = dot2.v;
      side2_nxt.ov = dot2.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side2_nxt;
      sqs2_r  <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  // square root of |a|^2
  logic [W-1:0] norm;
  v3an_pkg::side_t side_sq_r [SQN];

  v3an_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sqs2_r),
    .root (norm)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq_r[0] <= side2_r;
      for (int k = 1; k < SQN; k++) begin
        side_sq_r[k] <= side_sq_r[k-1];
      end
    end
  end

  // divider lanes
  v3an_pkg::side_t side3;
  v3an_pkg::sat_t  norm_sat;
  logic [W-1:0]    divisor3;
  logic            sneg3;
  logic [DW-1:0]   quot [3];
  logic            qneg [3];
  v3an_pkg::side_t side_dv_r [DVN];

  always_comb begin
    side3    = side_sq_r[SQN-1];
    norm_sat = v3an_pkg::sat_ext(EW'(norm));
    sneg3    = 1'b0;
    divisor3 = norm;
    case (side3.mode)
      v3an_pkg::MODE_NORM: begin
        side3.rs = norm_sat.v;
        side3.ov = norm_sat.ov;
      end
      v3an_pkg::MODE_NORMALIZE: begin
        side3.pass = (norm == '0) || (norm < W'(thr_r));
      end
      v3an_pkg::MODE_DIV: begin
        side3.dz = (side3.s == '0);
        sneg3    = side3.s[W-1];
        divisor3 = v3an_pkg::mag(side3.s);
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3an_div_lane u_div (
      .clk      (clk),
      .en       (en),
      .dividend ({v3an_pkg::mag(side3.a[i]), {FB{1'b0}}}),
      .divisor  (divisor3),
      .neg      (side3.a[i][W-1] ^ sneg3),
      .quot     (quot[i]),
      .quot_neg (qneg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dv_r[0] <= side3;
      for (int k = 1; k < DVN; k++) begin
        side_dv_r[k] <= side_dv_r[k-1];
      end
    end
  end

  // merge lanes and select the result
  v3an_pkg::side_t sdo;
  v3an_pkg::sat_t  fin [3];
  logic [W-1:0] res_x_r, res_y_r, res_z_r, res_s_r;
  logic         ov_r, dz_r;

  assign sdo = side_dv_r[DVN-1];

  for (genvar i = 0; i < 3; i++) begin : g_fin
    always_comb begin
      logic signed [EW-1:0] qv;
      qv = $signed({{(EW-DW){1'b0}}, quot[i]});
      if (qneg[i]) begin
        qv = -qv;
      end
      if (sdo.mode == v3an_pkg::MODE_DIV && sdo.dz) begin
        fin[i].ov = (sdo.a[i] != '0);
        if (sdo.a[i] == '0) begin
          fin[i].v = '0;
        end else begin
          fin[i].v = sdo.a[i][W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
      end else if (sdo.mode == v3an_pkg::MODE_DIV ||
                   (sdo.mode == v3an_pkg::MODE_NORMALIZE && !sdo.pass)) begin
        fin[i] = v3an_pkg::sat_ext(qv);
      end else if (sdo.mode == v3an_pkg::MODE_NORMALIZE) begin
        fin[i].v  = sdo.a[i];
        fin[i].ov = 1'b0;
      end else begin
        fin[i].v  = sdo.r[i];
        fin[i].ov = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r <= fin[0].v;
      res_y_r <= fin[1].v;
      res_z_r <= fin[2].v;
      res_s_r <= sdo.rs;
      ov_r    <= sdo.ov | fin[0].ov | fin[1].ov | fin[2].ov;
      dz_r    <= sdo.dz;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.res_x      = res_x_r;
  assign out_ch.res_y      = res_y_r;
  assign out_ch.res_z      = res_z_r;
  assign out_ch.res_scalar = res_s_r;
  assign out_ch.overflow   = ov_r;
  assign out_ch.div_zero   = dz_r;

endmodule
`default_nettype wire

// ----- test/vec3_alu_normalize_tb.sv -----
// Self-checking testbench for vec3_alu_normalize: random and directed vector operations.
`default_nettype none
module vec3_alu_normalize_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [69:0] wide_t;

  typedef struct {
    v3an_pkg::mode_t    mode;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } vec_op_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic signed [31:0] rs;
    logic               ov;
    logic               dz;
  } vec_res_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [v3an_pkg::THR_W-1:0] cfg_wdata = '0;

  v3an_in_if  in_ch ();
  v3an_out_if out_ch ();

  vec3_alu_normalize u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  vec_op_t     pending_ops [$];
  vec_res_t    expected_res [$];
  vec_op_t     cur_op;
  logic [15:0] threshold = v3an_pkg::THR_RESET;
  int          src_idle = 0;
  int          snk_idle = 0;
  bit          in_xfer = 1'b0;
  int          errors = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_ovf = 0;
  int          n_dz = 0;
  int          stall_cycles = 0;

  function automatic logic [32:0] clamp32(wide_t v);
    if (v > wide_t'(64'sd2147483647)) return {1'b1, 32'h7fffffff};
    if (v < -wide_t'(64'sd2147483648)) return {1'b1, 32'h80000000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic wide_t div_trunc(logic signed [31:0] x, logic [63:0] dm, bit dneg);
    logic [63:0] m;
    logic [63:0] q;
    m = x[31] ? 64'(-wide_t'(x)) : 64'(x);
    q = (m << v3an_pkg::FRAC_BITS) / dm;
    return (x[31] != dneg) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic logic [63:0] vec_norm(logic signed [31:0] a [3]);
    logic [63:0] sum;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] bitv;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m = a[i][31] ? 64'(-wide_t'(a[i])) : 64'(a[i]);
      sum += m * m;
    end
    r = '0;
    bitv = 64'd1 << 62;
    while (bitv > sum) bitv >>= 2;
    while (bitv != 0) begin
      if (sum >= r + bitv) begin
        sum -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic vec_res_t predict_vec_op(vec_op_t op, logic [15:0] thr);
    wide_t       v [3];
    wide_t       sc;
    logic [63:0] n;
    logic [32:0] c;
    bit          ov;
    bit          dz;
    bit          scal;
    vec_res_t    res;
    ov = 0;
    dz = 0;
    scal = 0;
    sc = '0;
    for (int i = 0; i < 3; i++) v[i] = '0;
    case (op.mode)
      v3an_pkg::MODE_ADD: begin
        for (int i = 0; i < 3; i++) v[i] = wide_t'(op.a[i]) + wide_t'(op.b[i]);
      end
      v3an_pkg::MODE_SUB: begin
        for (int i = 0; i < 3; i++) v[i] = wide_t'(op.a[i]) - wide_t'(op.b[i]);
      end
      v3an_pkg::MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          v[i] = (wide_t'(op.a[i]) * wide_t'(op.s)) >>> v3an_pkg::FRAC_BITS;
        end
      end
      v3an_pkg::MODE_DIV: begin
        if (op.s == 0) begin
          dz = 1;
          for (int i = 0; i < 3; i++) begin
            if (op.a[i] > 0) begin
              v[i] = wide_t'(64'sd2147483647);
              ov = 1;
            end else if (op.a[i] < 0) begin
              v[i] = -wide_t'(64'sd2147483648);
              ov = 1;
            end
          end
        end else begin
          n = op.s[31] ? 64'(-wide_t'(op.s)) : 64'(op.s);
          for (int i = 0; i < 3; i++) v[i] = div_trunc(op.a[i], n, op.s[31]);
        end
      end
      v3an_pkg::MODE_DOT: begin
        for (int i = 0; i < 3; i++) sc += wide_t'(op.a[i]) * wide_t'(op.b[i]);
        sc = sc >>> v3an_pkg::FRAC_BITS;
        scal = 1;
      end
      v3an_pkg::MODE_CROSS: begin
        v[0] = (wide_t'(op.a[1]) * op.b[2] - wide_t'(op.a[2]) * op.b[1])
               >>> v3an_pkg::FRAC_BITS;
        v[1] = (wide_t'(op.a[2]) * op.b[0] - wide_t'(op.a[0]) * op.b[2])
               >>> v3an_pkg::FRAC_BITS;
        v[2] = (wide_t'(op.a[0]) * op.b[1] - wide_t'(op.a[1]) * op.b[0])
               >>> v3an_pkg::FRAC_BITS;
      end
      v3an_pkg::MODE_NORM: begin
        sc = wide_t'(vec_norm(op.a));
        scal = 1;
      end
      default: begin
        n = vec_norm(op.a);
        for (int i = 0; i < 3; i++) begin
          if (n == 0 || n < 64'(thr)) v[i] = wide_t'(op.a[i]);
          else v[i] = div_trunc(op.a[i], n, 1'b0);
        end
      end
    endcase
    if (scal) begin
      for (int i = 0; i < 3; i++) res.r[i] = '0;
      c = clamp32(sc);
      res.rs = c[31:0];
      ov |= c[32];
    end else begin
      for (int i = 0; i < 3; i++) begin
        c = clamp32(v[i]);
        res.r[i] = c[31:0];
        ov |= c[32];
      end
      res.rs = '0;
    end
    res.ov = ov;
    res.dz = dz;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_component();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 64)) - 32'sd32;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh00010000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic vec_op_t rand_vec_op();
    vec_op_t op;
    op.mode = v3an_pkg::mode_t'($urandom_range(7));
    for (int i = 0; i < 3; i++) begin
      op.a[i] = rand_component();
      op.b[i] = rand_component();
    end
    op.s = ($urandom_range(9) == 0) ? 32'sd0 : rand_component();
    return op;
  endfunction

  function automatic vec_op_t make_op(v3an_pkg::mode_t m, logic signed [31:0] ax,
                                      logic signed [31:0] ay, logic signed [31:0] az,
                                      logic signed [31:0] bv, logic signed [31:0] sv);
    vec_op_t op;
    op.mode = m;
    op.a[0] = ax;
    op.a[1] = ay;
    op.a[2] = az;
    for (int i = 0; i < 3; i++) op.b[i] = bv;
    op.s = sv;
    return op;
  endfunction

  // driver: advance on transfer, hold otherwise
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_xfer)) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle) begin
        cur_op = pending_ops.pop_front();
        in_ch.mode      <= cur_op.mode;
        in_ch.a_x       <= cur_op.a[0];
        in_ch.a_y       <= cur_op.a[1];
        in_ch.a_z       <= cur_op.a[2];
        in_ch.b_x       <= cur_op.b[0];
        in_ch.b_y       <= cur_op.b[1];
        in_ch.b_z       <= cur_op.b[2];
        in_ch.scalar_in <= cur_op.s;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    in_xfer = rst_n && in_ch.valid && in_ch.ready;
    if (in_xfer) begin
      expected_res.push_back(predict_vec_op(cur_op, threshold));
      n_in++;
    end
  end

  // monitor
  always @(posedge clk) begin
    vec_res_t ex;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (expected_res.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        ex = expected_res.pop_front();
        if (out_ch.overflow) n_ovf++;
        if (out_ch.div_zero) n_dz++;
        if (out_ch.res_x !== ex.r[0]) begin
          $error("res_x expected %h actual %h", ex.r[0], out_ch.res_x);
          errors++;
        end
        if (out_ch.res_y !== ex.r[1]) begin
          $error("res_y expected %h actual %h", ex.r[1], out_ch.res_y);
          errors++;
        end
        if (out_ch.res_z !== ex.r[2]) begin
          $error("res_z expected %h actual %h", ex.r[2], out_ch.res_z);
          errors++;
        end
        if (out_ch.res_scalar !== ex.rs) begin
          $error("res_scalar expected %h actual %h", ex.rs, out_ch.res_scalar);
          errors++;
        end
        if (out_ch.overflow !== ex.ov) begin
          $error("overflow expected %b actual %b", ex.ov, out_ch.overflow);
          errors++;
        end
        if (out_ch.div_zero !== ex.dz) begin
          $error("div_zero expected %b actual %b", ex.dz, out_ch.div_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired: %0d sent, %0d received", n_in, n_out);
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_ch.valid || expected_res.size() > 0) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    threshold = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending_ops.push_back(rand_vec_op());
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.a_x = '0;
    in_ch.a_y = '0;
    in_ch.a_z = '0;
    in_ch.b_x = '0;
    in_ch.b_y = '0;
    in_ch.b_z = '0;
    in_ch.scalar_in = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    src_idle = 32;
    snk_idle = 60;
    for (int m = 0; m < 8; m++) begin
      pending_ops.push_back(make_op(v3an_pkg::mode_t'(m), 32'sh7fffffff, 32'sh80000000,
                                    32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    end
    pending_ops.push_back(make_op(v3an_pkg::MODE_DIV, 32'sd5, -32'sd3, 32'sd0, 32'sd0,
                                  32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_DIV, 32'sh80000000, 32'sd1, -32'sd7,
                                  32'sd0, -32'sh10000));
    pending_ops.push_back(make_op(v3an_pkg::MODE_NORMALIZE, 32'sd0, 32'sd0, 32'sd0,
                                  32'sd0, 32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_NORMALIZE, 32'sd3, -32'sd2, 32'sd4,
                                  32'sd0, 32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_NORMALIZE, 32'sd7, 32'sd0, 32'sd0,
                                  32'sd0, 32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_NORMALIZE, 32'sh30000, 32'sh40000,
                                  32'sd0, 32'sd0, 32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_NORM, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sd0, 32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_SCALE, -32'sd1, 32'sd1, 32'sh10000,
                                  32'sd0, -32'sd1));
    pending_ops.push_back(make_op(v3an_pkg::MODE_DOT, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000, 32'sd0));
    pending_ops.push_back(make_op(v3an_pkg::MODE_CROSS, 32'sh10000, 32'sh20000,
                                  -32'sh30000, 32'sh7fffffff, 32'sd0));
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    write_threshold(16'd0);
    run_random(410);
    repeat (DRAIN_CYCLES) @(negedge clk);

    src_idle = 60;
    snk_idle = 32;
    write_threshold(16'hffff);
    run_random(410);
    repeat (DRAIN_CYCLES) @(negedge clk);

    src_idle = 0;
    snk_idle = 0;
    write_threshold(16'($urandom_range(1, 65534)));
    run_random(410);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d operations over all modes, %0d overflow and %0d divide-by-zero",
             n_in, n_ovf, n_dz);
    $display("results; thresholds 7, 0, 65535 and a random one; mixed and no backpressure");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
